@@ rtl/core/rgla_pkg.sv @@
// Package for the running GCD / LCM accumulator.
// Holds the value width, the controller/datapath command and status structs,
// and the working-register type of the binary GCD units. No dependencies.
package rgla_pkg;

  // Width of one duration value and of both accumulators
  localparam int unsigned W     = 32;
  // Bits for a step counter over W steps and for the common power-of-two count
  localparam int unsigned CNT_W = $clog2(W);

  // Working registers of one binary GCD unit
  typedef struct packed {
    logic [W-1:0]     a;
    logic [W-1:0]     b;
    logic [CNT_W-1:0] k;
  } bgcd_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic load;       // take the input item, apply the start mark
    logic gcd_step;   // one step of both GCD units
    logic gcd_latch;  // store the set GCD, load the divider
    logic div_step;   // one bit of the restoring divide
    logic mul;        // register quotient times duration
    logic upd;        // update LCM and overflow from the product
    logic out_load;   // fill the output register
  } cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic gcd_done;   // both GCD units have finished
    logic skip_lcm;   // zero duration or set already saturated
    logic div_last;   // divider is on its final bit
    logic out_free;   // output register is empty or being taken
  } sts_t;

endpackage

@@ rtl/core/rgla_ctrl.sv @@
// Controller state machine for the running GCD / LCM accumulator.
// Sequences one item through GCD, divide, multiply and update.
// Depends on rgla_pkg (cmd_t, sts_t).
module rgla_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  rgla_pkg::sts_t sts,
  output rgla_pkg::cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_GCD  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_GCD;
        end
      end
      S_GCD: begin
        if (sts.gcd_done) begin
          cmd.gcd_latch = 1'b1;
          state_next    = sts.skip_lcm ? S_OUT : S_DIV;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_UPD;
      end
      S_UPD: begin
        cmd.upd    = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ rtl/core/rgla_dp.sv @@
// Datapath for the running GCD / LCM accumulator: accumulators, two binary
// GCD units, a restoring divider, one multiplier and the output register.
// Depends on rgla_pkg (W, CNT_W, bgcd_t, cmd_t, sts_t).
module rgla_dp (
  input  logic                    clk,
  input  logic                    rst,
  input  rgla_pkg::cmd_t          cmd,
  output rgla_pkg::sts_t          sts,
  input  logic [rgla_pkg::W-1:0]  in_duration,
  input  logic                    in_start,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [rgla_pkg::W-1:0]  out_gcd,
  output logic [rgla_pkg::W-1:0]  out_lcm,
  output logic                    out_ovf
);

  localparam int unsigned W     = rgla_pkg::W;
  localparam int unsigned CNT_W = rgla_pkg::CNT_W;

  // Accumulators
  logic [W-1:0] gcd_acc;
  logic [W-1:0] lcm_acc;
  logic         ovf;
  logic [W-1:0] dur;

  // GCD units: u1 on (gcd_acc, d), u2 on (lcm_acc, d)
  rgla_pkg::bgcd_t u1;
  rgla_pkg::bgcd_t u2;
  rgla_pkg::bgcd_t u1_next;
  rgla_pkg::bgcd_t u2_next;
  logic [W-1:0]    g1;
  logic [W-1:0]    g2;

  // Divider and product
  logic [W-1:0]     quo;
  logic [W-1:0]     rem;
  logic [W-1:0]     dvs;
  logic [CNT_W-1:0] cnt;
  logic [W:0]       trial;
  logic [W:0]       diff;
  logic [2*W-1:0]   prod;

  // One Stein step: shift out twos, or halve the odd difference
  function automatic rgla_pkg::bgcd_t bgcd_step(input rgla_pkg::bgcd_t s);
    rgla_pkg::bgcd_t r;
    r = s;
    if (s.a == '0 || s.b == '0) begin
      r = s;
    end else if (!s.a[0] && !s.b[0]) begin
      r.a = s.a >> 1;
      r.b = s.b >> 1;
      r.k = s.k + 1'b1;
    end else if (!s.a[0]) begin
      r.a = s.a >> 1;
    end else if (!s.b[0]) begin
      r.b = s.b >> 1;
    end else if (s.a >= s.b) begin
      r.a = (s.a - s.b) >> 1;
    end else begin
      r.b = (s.b - s.a) >> 1;
    end
    return r;
  endfunction

  assign u1_next = bgcd_step(u1);
  assign u2_next = bgcd_step(u2);
  assign g1      = (u1.a | u1.b) << u1.k;
  assign g2      = (u2.a | u2.b) << u2.k;

  // Restoring divide bit
  assign trial = {rem, quo[W-1]};
  assign diff  = trial - {1'b0, dvs};

  // Status
  assign sts.gcd_done = (u1.a == '0 || u1.b == '0) && (u2.a == '0 || u2.b == '0);
  assign sts.skip_lcm = (dur == '0) || ovf;
  assign sts.div_last = (cnt == CNT_W'(W - 1));
  assign sts.out_free = !out_valid || out_ready;

  // Accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      gcd_acc <= '0;
      lcm_acc <= W'(1);
      ovf     <= 1'b0;
    end else if (cmd.load && in_start) begin
      gcd_acc <= '0;
      lcm_acc <= W'(1);
      ovf     <= 1'b0;
    end else if (cmd.gcd_latch) begin
      gcd_acc <= g1;
    end else if (cmd.upd) begin
      if (prod[2*W-1:W] != '0) begin
        lcm_acc <= '1;
        ovf     <= 1'b1;
      end else begin
        lcm_acc <= prod[W-1:0];
      end
    end
  end

  // GCD units
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dur  <= in_duration;
      u1.a <= in_start ? '0 : gcd_acc;
      u1.b <= in_duration;
      u1.k <= '0;
      u2.a <= in_start ? W'(1) : lcm_acc;
      u2.b <= in_duration;
      u2.k <= '0;
    end else if (cmd.gcd_step) begin
      u1 <= u1_next;
      u2 <= u2_next;
    end
  end

  // Divider: lcm_acc / gcd(lcm_acc, d)
  always_ff @(posedge clk) begin
    if (cmd.gcd_latch) begin
      quo <= lcm_acc;
      rem <= '0;
      dvs <= g2;
      cnt <= '0;
    end else if (cmd.div_step) begin
      cnt <= cnt + 1'b1;
      if (!diff[W]) begin
        rem <= diff[W-1:0];
        quo <= {quo[W-2:0], 1'b1};
      end else begin
        rem <= trial[W-1:0];
        quo <= {quo[W-2:0], 1'b0};
      end
    end
  end

  // Quotient times duration
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod <= {{W{1'b0}}, quo} * {{W{1'b0}}, dur};
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_gcd <= gcd_acc;
      out_lcm <= lcm_acc;
      out_ovf <= ovf;
    end
  end

  // A saturated set always holds an all-ones LCM
  a_ovf_sat: assert property (@(posedge clk) disable iff (rst)
    ovf |-> (lcm_acc == '1))
    else $error("overflow set without saturated LCM");

  // The divisor handed to the divider is never zero
  a_dvs_nz: assert property (@(posedge clk) disable iff (rst)
    (cmd.gcd_latch && !sts.skip_lcm) |=> (dvs != '0))
    else $error("zero divisor loaded");

  // The GCD divides the LCM exactly
  a_rem_zero: assert property (@(posedge clk) disable iff (rst)
    cmd.mul |-> (rem == '0))
    else $error("nonzero remainder in LCM divide");

  // The LCM accumulator never reaches zero
  a_lcm_nz: assert property (@(posedge clk) disable iff (rst)
    cmd.upd |=> (lcm_acc != '0))
    else $error("LCM accumulator became zero");

endmodule

@@ rtl/core/running_gcd_lcm_accumulator.sv @@
// Running GCD / LCM accumulator over a set of durations, one value per item.
// Input item: s_tdata = duration, s_tuser = start of a new set. Each input
// item yields one result item: m_tdata = {set_lcm, set_gcd},
// m_tuser = sticky LCM overflow flag of the current set.
// One item is worked on at a time. From input accept to m_tvalid the item
// passes through the two binary GCD units running side by side, then the
// bit-serial divider, then the multiply, update and output load states. A
// zero duration or a saturated set skips the divide, multiply and update.
// The GCD loop and the divider set the item time.
// The result sits in an output register, so s_tready returns as soon as the
// result is loaded; a stalled receiver only holds the next result at its
// final step until m_tready frees the register.
// Reset (rst, synchronous) empties the set: GCD 0, LCM 1, flag clear, and
// drops any pending result.
// Depends on rgla_pkg, rgla_ctrl and rgla_dp.
module running_gcd_lcm_accumulator (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [rgla_pkg::W-1:0]    s_tdata,   // [31:0] duration
  input  logic                      s_tuser,   // [0] start_set
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [2*rgla_pkg::W-1:0]  m_tdata,   // [31:0] set_gcd, [63:32] set_lcm
  output logic                      m_tuser    // [0] lcm_overflow
);

  rgla_pkg::cmd_t        cmd;
  rgla_pkg::sts_t        sts;
  logic [rgla_pkg::W-1:0] res_gcd;
  logic [rgla_pkg::W-1:0] res_lcm;

  rgla_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rgla_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .in_duration (s_tdata),
    .in_start    (s_tuser),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_gcd     (res_gcd),
    .out_lcm     (res_lcm),
    .out_ovf     (m_tuser)
  );

  assign m_tdata = {res_lcm, res_gcd};

endmodule
